>>> rtl/core/blocked_bloom_filter_top_assert.svh
// assertion macros shared by the checker of the bloom filter block
`ifndef BLOCKED_BLOOM_FILTER_TOP_ASSERT_SVH
`define BLOCKED_BLOOM_FILTER_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define BBF_ASSERT_NOW(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("bbf assertion failed");

// antecedent at one edge implies consequent at the next edge
`define BBF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bbf assertion failed");

// condition holds at every edge of an applied reset after its first edge
`define BBF_ASSERT_RST(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) (!rstn && $past(!rstn)) |-> (cond)) \
        else $error("bbf assertion failed");

`endif

>>> rtl/core/bbf_pkg.sv
// ----------------------------------------------------------------------------
// bbf_pkg
// Shared types, codes and helper functions of the blocked bloom filter.
// ----------------------------------------------------------------------------
package bbf_pkg;

    // default geometry
    localparam int WORD_INDEX_BITS = 9;
    localparam int MAX_PAGE_BITS   = 6;

    // fixed field widths
    localparam int HASH_W      = 64;
    localparam int WORD_W      = 64;
    localparam int SLICE_W     = 6;
    localparam int NUM_SLICES  = 5;
    localparam int WORD_SEL_LO = 30;
    localparam int PAGE_REG_W  = 3;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_BITS = 1'b1;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // command queue between front and back, depth is a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // work classes handed to the back end
    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_HIT
    } bbf_op_e;

    // command control from front to back
    typedef struct packed {
        logic    valid;
        bbf_op_e op;
    } bbf_cmd_ctl_t;

    // sets the bit picked by each of the five low hash slices (they may pick the same bit)
    function automatic logic [WORD_W-1:0] bbf_mask(input logic [HASH_W-1:0] h);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int i = 0; i < NUM_SLICES; i++)
        begin
            m[h[i*SLICE_W +: SLICE_W]] = 1'b1;
        end
        return m;
    endfunction

endpackage

>>> rtl/core/bbf_front.sv
// ----------------------------------------------------------------------------
// bbf_front
// Holds the configuration, accepts requests, works out word address and mask,
// classifies each request and queues the work for the back end.
// ----------------------------------------------------------------------------
module bbf_front #(
    parameter int WORD_INDEX_BITS = bbf_pkg::WORD_INDEX_BITS,
    parameter int MAX_PAGE_BITS   = bbf_pkg::MAX_PAGE_BITS,
    localparam int AddrW          = MAX_PAGE_BITS + WORD_INDEX_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request side
    input  logic                           push,
    output logic                           full,
    input  logic                           req_type,
    input  logic [bbf_pkg::HASH_W-1:0]     hash,
    // configuration
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bbf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bbf_pkg::CFG_DATA_W-1:0] cfg_data,
    // command queue head toward the back end
    output bbf_pkg::bbf_cmd_ctl_t          cmd_ctl,
    output logic [AddrW-1:0]               cmd_addr,
    output logic [bbf_pkg::WORD_W-1:0]     cmd_mask,
    input  logic                           cmd_pop,
    input  logic                           clearing
);

    localparam int PgW = $clog2(MAX_PAGE_BITS + 1);

    logic                               enable_reg;
    logic [bbf_pkg::PAGE_REG_W-1:0]     page_bits_reg;

    logic [PgW-1:0]                     pb_eff;
    logic [PgW-1:0]                     pg_shift;
    logic [MAX_PAGE_BITS-1:0]           page;
    logic [AddrW-1:0]                   addr;
    logic [bbf_pkg::WORD_W-1:0]         mask;
    bbf_pkg::bbf_op_e                   op;
    logic                               needs_work;
    logic                               accept;
    logic                               enq;

    bbf_pkg::bbf_op_e                   op_q   [bbf_pkg::QUEUE_DEPTH];
    logic [AddrW-1:0]                   addr_q [bbf_pkg::QUEUE_DEPTH];
    logic [bbf_pkg::WORD_W-1:0]         mask_q [bbf_pkg::QUEUE_DEPTH];
    logic [bbf_pkg::QPTR_W-1:0]         wr_ptr_reg;
    logic [bbf_pkg::QPTR_W-1:0]         rd_ptr_reg;
    logic [bbf_pkg::QCNT_W-1:0]         count_reg;
    logic                               q_full;

    // configuration registers, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            page_bits_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bbf_pkg::CFG_ENABLE:    enable_reg    <= cfg_data[0];
                bbf_pkg::CFG_PAGE_BITS: page_bits_reg <= cfg_data[bbf_pkg::PAGE_REG_W-1:0];
                default:                enable_reg    <= enable_reg;
            endcase
        end
    end

    // page count saturates at the largest supported size
    always_comb
    begin
        if (int'(page_bits_reg) > MAX_PAGE_BITS)
        begin
            pb_eff = PgW'(MAX_PAGE_BITS);
        end
        else
        begin
            pb_eff = PgW'(page_bits_reg);
        end
    end

    // page from the top hash bits, word from the middle, mask from the bottom
    assign pg_shift = PgW'(MAX_PAGE_BITS) - pb_eff;
    assign page     = hash[bbf_pkg::HASH_W-1 -: MAX_PAGE_BITS] >> pg_shift;
    assign addr     = {page, hash[bbf_pkg::WORD_SEL_LO +: WORD_INDEX_BITS]};
    assign mask     = bbf_pkg::bbf_mask(hash);

    // classify: dropped inserts never reach the queue
    always_comb
    begin
        op         = bbf_pkg::OP_READ;
        needs_work = 1'b1;
        if (req_type == bbf_pkg::REQ_INSERT)
        begin
            op         = bbf_pkg::OP_WRITE;
            needs_work = enable_reg && (pb_eff != '0);
        end
        else if (pb_eff == '0)
        begin
            op = bbf_pkg::OP_HIT;
        end
    end

    assign q_full = (count_reg == bbf_pkg::QCNT_W'(bbf_pkg::QUEUE_DEPTH));
    assign full   = q_full || clearing;
    assign accept = push && !full;
    assign enq    = accept && needs_work;

    // queue storage
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            op_q[wr_ptr_reg]   <= op;
            addr_q[wr_ptr_reg] <= addr;
            mask_q[wr_ptr_reg] <= mask;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (enq)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (enq && !cmd_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!enq && cmd_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // queue head
    assign cmd_ctl.valid = (count_reg != '0);
    assign cmd_ctl.op    = op_q[rd_ptr_reg];
    assign cmd_addr      = addr_q[rd_ptr_reg];
    assign cmd_mask      = mask_q[rd_ptr_reg];

endmodule

>>> rtl/core/bbf_back.sv
// ----------------------------------------------------------------------------
// bbf_back
// Owns the word memory: clears it after reset, then runs one read-modify-write
// or lookup per queued command and holds the result for the consumer.
// ----------------------------------------------------------------------------
module bbf_back #(
    parameter int WORD_INDEX_BITS = bbf_pkg::WORD_INDEX_BITS,
    parameter int MAX_PAGE_BITS   = bbf_pkg::MAX_PAGE_BITS,
    localparam int AddrW          = MAX_PAGE_BITS + WORD_INDEX_BITS,
    localparam int Depth          = 2 ** AddrW
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // command queue head
    input  bbf_pkg::bbf_cmd_ctl_t          cmd_ctl,
    input  logic [AddrW-1:0]               cmd_addr,
    input  logic [bbf_pkg::WORD_W-1:0]     cmd_mask,
    output logic                           cmd_pop,
    output logic                           clearing,
    // result side
    output logic                           empty,
    input  logic                           pop,
    output logic                           maybe_present
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                         state_reg,     state_next;
    logic [AddrW-1:0]               clr_addr_reg,  clr_addr_next;
    bbf_pkg::bbf_op_e               op_reg,        op_next;
    logic [AddrW-1:0]               addr_reg,      addr_next;
    logic [bbf_pkg::WORD_W-1:0]     mask_reg,      mask_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_data_reg,  out_data_next;

    logic [bbf_pkg::WORD_W-1:0]     mem [Depth];
    logic [bbf_pkg::WORD_W-1:0]     rdata_reg;
    logic                           mem_we;
    logic [AddrW-1:0]               mem_waddr;
    logic [bbf_pkg::WORD_W-1:0]     mem_wdata;
    logic                           mem_re;
    logic                           slot_free;

    assign slot_free = !out_valid_reg || pop;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg && !pop;
        out_data_next  = out_data_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = rdata_reg | mask_reg;
        mem_re         = 1'b0;

        unique case (state_reg)
            // zero one word per cycle
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (&clr_addr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            // take the next command
            ST_IDLE:
            begin
                if (cmd_ctl.valid)
                begin
                    case (cmd_ctl.op) inside
                        bbf_pkg::OP_HIT:
                        begin
                            if (slot_free)
                            begin
                                cmd_pop        = 1'b1;
                                out_valid_next = 1'b1;
                                out_data_next  = 1'b1;
                            end
                        end
                        bbf_pkg::OP_READ, bbf_pkg::OP_WRITE:
                        begin
                            cmd_pop    = 1'b1;
                            mem_re     = 1'b1;
                            op_next    = cmd_ctl.op;
                            addr_next  = cmd_addr;
                            mask_next  = cmd_mask;
                            state_next = ST_EXEC;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            // word is back: merge the mask or test it
            ST_EXEC:
            begin
                case (op_reg)
                    bbf_pkg::OP_WRITE:
                    begin
                        mem_we     = 1'b1;
                        state_next = ST_IDLE;
                    end
                    bbf_pkg::OP_READ:
                    begin
                        if (slot_free)
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = ((rdata_reg & mask_reg) == mask_reg);
                            state_next     = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            op_reg        <= bbf_pkg::OP_READ;
            addr_reg      <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            op_reg        <= op_next;
            addr_reg      <= addr_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // word memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[cmd_addr];
        end
    end

    assign clearing      = (state_reg == ST_CLEAR);
    assign empty         = !out_valid_reg;
    assign maybe_present = out_data_reg;

endmodule

>>> rtl/core/blocked_bloom_filter_top.sv
// A lookup passes the command queue, the memory read and the result register (no memory
// read when no filter is built); the back end finishes each memory command before the next,
// and the 2-entry command queue lets requests be taken while the back end is busy.
// Reset: asynchronous, active low; configuration returns to zero and the word memory
// is then zeroed one word per cycle, all 2**(MAX_PAGE_BITS + WORD_INDEX_BITS) words
// (32768 by default), with full held high; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// blocked_bloom_filter_top
// Register-blocked bloom filter over a 64-bit hash with insert and lookup.
// ----------------------------------------------------------------------------
module blocked_bloom_filter_top #(
    parameter int WORD_INDEX_BITS = bbf_pkg::WORD_INDEX_BITS,
    parameter int MAX_PAGE_BITS   = bbf_pkg::MAX_PAGE_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request queue side
    input  logic                            push,
    output logic                            full,
    input  logic                            req_type,
    input  logic [bbf_pkg::HASH_W-1:0]      hash,
    // result queue side
    output logic                            empty,
    input  logic                            pop,
    output logic                            maybe_present,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bbf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bbf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int AddrW = MAX_PAGE_BITS + WORD_INDEX_BITS;

    bbf_pkg::bbf_cmd_ctl_t          cmd_ctl;
    logic [AddrW-1:0]               cmd_addr;
    logic [bbf_pkg::WORD_W-1:0]     cmd_mask;
    logic                           cmd_pop;
    logic                           clearing;

    // request intake and classification
    bbf_front #(
        .WORD_INDEX_BITS (WORD_INDEX_BITS),
        .MAX_PAGE_BITS   (MAX_PAGE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .hash      (hash),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_ctl   (cmd_ctl),
        .cmd_addr  (cmd_addr),
        .cmd_mask  (cmd_mask),
        .cmd_pop   (cmd_pop),
        .clearing  (clearing)
    );

    // memory access and results
    bbf_back #(
        .WORD_INDEX_BITS (WORD_INDEX_BITS),
        .MAX_PAGE_BITS   (MAX_PAGE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_ctl       (cmd_ctl),
        .cmd_addr      (cmd_addr),
        .cmd_mask      (cmd_mask),
        .cmd_pop       (cmd_pop),
        .clearing      (clearing),
        .empty         (empty),
        .pop           (pop),
        .maybe_present (maybe_present)
    );

endmodule

>>> rtl/core/bbf_checker.sv
// ----------------------------------------------------------------------------
// bbf_checker
// Port-level checks on the bloom filter top, attached by bind.
// ----------------------------------------------------------------------------
`include "blocked_bloom_filter_top_assert.svh"

module bbf_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            push,
    input logic                            full,
    input logic                            req_type,
    input logic [bbf_pkg::HASH_W-1:0]      hash,
    input logic                            empty,
    input logic                            pop,
    input logic                            maybe_present,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [bbf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [bbf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // in reset no results are shown and requests are held off for the clear
    `BBF_ASSERT_RST(a_reset_state, clk, rst_n, full && empty)

    // configuration is never back-pressured
    `BBF_ASSERT_NOW(a_cfg_ready, clk, rst_n, cfg_ready)

    // a waiting result stays until taken
    `BBF_ASSERT_NEXT(a_result_held, clk, rst_n, !empty && !pop, !empty)

    // and its value does not change meanwhile
    `BBF_ASSERT_NEXT(a_result_stable, clk, rst_n, !empty && !pop, $stable(maybe_present))

endmodule

bind blocked_bloom_filter_top bbf_checker u_bbf_checker (.*);
